// File: rtl/assert_macros.svh
// assertion helpers used by the top-level module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MLPH_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// next-cycle implication
`define MLPH_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/mlph_pkg.sv
package mlph_pkg;

    localparam int LANES      = 4;
    localparam int NUM_PRIMES = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int PRIME_W    = 31;
    localparam int LANE_W     = 2;
    localparam int LANE_IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;

    localparam logic [31:0] HASH_SEED = 32'd1804289383;
    localparam logic [31:0] HASH_MOD  = 32'd2147483629;
    // 2^31 mod HASH_MOD
    localparam logic [12:0] MOD_FOLD  = 13'd19;

    localparam logic [PRIME_W-1:0] PRIME_RESET [NUM_PRIMES] =
        '{31'd31, 31'd37, 31'd41, 31'd43};

    typedef struct packed {
        logic signed [7:0] ch;
        logic              use_ch;
        logic              last;
    } item_t;

endpackage

// File: rtl/mlph_front.sv
module mlph_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // key_byte
    input  logic             s_tuser,   // has_byte
    input  logic             s_tlast,   // end_of_key
    output logic             q_valid,
    input  logic             q_pop,
    output mlph_pkg::item_t  q_item
);
    import mlph_pkg::*;

    item_t          fifo_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   count_reg, count_next;
    logic           push, pop;
    item_t          in_item;

    // a zero character never belongs to a key
    always_comb
    begin
        in_item.ch     = s_tdata;
        in_item.use_ch = s_tuser && (s_tdata != 8'd0);
        in_item.last   = s_tlast;
    end

    assign s_tready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/mlph_lanes.sv
module mlph_lanes (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mlph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlph_pkg::PRIME_W-1:0]      cfg_data,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  mlph_pkg::item_t                   q_item,
    input  logic                              emit_can_load,
    output logic                              snap_load,
    output logic [mlph_pkg::LANES-1:0][31:0]  snap_hash
);
    import mlph_pkg::*;

    logic [PRIME_W-1:0] prime_reg [NUM_PRIMES];
    logic [31:0]        power_reg [LANES];
    logic [31:0]        hash_reg  [LANES];
    logic               fresh_reg;

    // stage 1: signed product, stage 2: folded magnitude, stage 3: signed remainder
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_use_reg, s2_use_reg, s3_use_reg;
    logic               s1_last_reg, s2_last_reg, s3_last_reg;
    logic signed [39:0] s1_prod_reg [LANES];
    logic               s2_neg_reg  [LANES];
    logic [31:0]        s2_fold_reg [LANES];
    logic [31:0]        s3_rem_reg  [LANES];

    logic               adv;
    logic               take;

    // the whole pipe holds while a finished key waits for the emitter
    assign adv       = !(s3_valid_reg && s3_last_reg && !emit_can_load);
    assign take      = adv && q_valid;
    assign q_pop     = take;
    assign snap_load = adv && s3_valid_reg && s3_last_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            snap_hash[i] = hash_reg[i] + (s3_use_reg ? s3_rem_reg[i] : 32'd0);
        end
    end

    // primes, power words and the fresh flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PRIMES; i++)
            begin
                prime_reg[i] <= PRIME_RESET[i];
            end
            for (int i = 0; i < LANES; i++)
            begin
                power_reg[i] <= {1'b0, PRIME_RESET[i]};
            end
            fresh_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                prime_reg[cfg_index] <= cfg_data;
                for (int i = 0; i < LANES; i++)
                begin
                    if (fresh_reg && (cfg_index == CFG_IDX_W'(i)))
                    begin
                        power_reg[i] <= {1'b0, cfg_data};
                    end
                end
            end
            if (take)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (q_item.last)
                    begin
                        power_reg[i] <= {1'b0, prime_reg[i]};
                    end
                    else if (q_item.use_ch)
                    begin
                        power_reg[i] <= 32'(power_reg[i] * {1'b0, prime_reg[i]});
                    end
                end
                if (q_item.last)
                begin
                    fresh_reg <= 1'b1;
                end
                else if (q_item.use_ch)
                begin
                    fresh_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                hash_reg[i] <= HASH_SEED;
            end
        end
        else if (adv)
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    hash_reg[i] <= s3_last_reg ? HASH_SEED : snap_hash[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [39:0] mag;
        logic [12:0] hi_fold;
        logic [31:0] red;
        if (adv)
        begin
            s1_use_reg  <= q_item.use_ch;
            s1_last_reg <= q_item.last;
            s2_use_reg  <= s1_use_reg;
            s2_last_reg <= s1_last_reg;
            s3_use_reg  <= s2_use_reg;
            s3_last_reg <= s2_last_reg;
            for (int i = 0; i < LANES; i++)
            begin
                s1_prod_reg[i] <= $signed(power_reg[i]) * q_item.ch;

                // |prod| < 2^39: fold the bits above 2^31 back in as 19 per unit
                mag = s1_prod_reg[i][39] ? 40'(-s1_prod_reg[i]) : 40'(s1_prod_reg[i]);
                hi_fold = 13'(mag[38:31]) * MOD_FOLD;
                s2_neg_reg[i]  <= s1_prod_reg[i][39];
                s2_fold_reg[i] <= {1'b0, mag[30:0]} + 32'(hi_fold);

                // folded value stays below twice the modulus
                red = (s2_fold_reg[i] >= HASH_MOD) ? (s2_fold_reg[i] - HASH_MOD)
                                                   : s2_fold_reg[i];
                s3_rem_reg[i] <= s2_neg_reg[i] ? (32'd0 - red) : red;
            end
        end
    end

endmodule

// File: rtl/mlph_emit.sv
module mlph_emit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              snap_load,
    input  logic [mlph_pkg::LANES-1:0][31:0]  snap_hash,
    output logic                              emit_can_load,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // hash_value
    output logic [mlph_pkg::LANE_W-1:0]       m_tuser,   // lane
    output logic                              m_tlast    // last_lane
);
    import mlph_pkg::*;

    logic [31:0]           hash_reg [LANES];
    logic [LANE_IDX_W-1:0] idx_reg;
    logic                  busy_reg;
    logic                  at_last;

    assign at_last       = (idx_reg == LANE_IDX_W'(LANES - 1));
    assign emit_can_load = !busy_reg || (m_tready && at_last);
    assign m_tvalid      = busy_reg;
    assign m_tdata       = hash_reg[idx_reg];
    assign m_tuser       = LANE_W'(idx_reg);
    assign m_tlast       = at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (snap_load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                hash_reg[i] <= snap_hash[i];
            end
        end
    end

endmodule

// File: rtl/multi_lane_poly_string_hash.sv
// multi-lane polynomial string hash
// slave stream: one key character per transfer, tdata = key_byte (signed),
// tuser = has_byte, tlast = end_of_key. a zero or absent character leaves
// every lane untouched; a tlast transfer finishes the key.
// master stream: per finished key, one transfer per lane in lane order,
// tdata = 32-bit hash, tuser = lane index, tlast on the final lane.
// cfg port: cfg_we/cfg_index/cfg_data write the lane primes 0..3, one per
// cycle, with the block idle. between keys a write also reloads the lane power.
// throughput: one character per cycle while the lane pipe is not held, set by
// the power multiply loop in each lane; a finished key occupies the master
// side with one transfer per lane. the tlast item passes from the 4-entry
// input queue through the product, fold and remainder stages to the output.
// master stall: results wait in the output register; the lane pipe holds only
// when a second finished key meets a still-busy output, and the input queue
// keeps taking characters until it is full.
// reset: hashes load the seed, primes and powers load their reset values,
// queue and output go empty.
`include "assert_macros.svh"

module multi_lane_poly_string_hash (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // key_byte
    input  logic                              s_tuser,   // has_byte
    input  logic                              s_tlast,   // end_of_key
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // hash_value
    output logic [mlph_pkg::LANE_W-1:0]       m_tuser,   // lane
    output logic                              m_tlast,   // last_lane
    input  logic                              cfg_we,
    input  logic [mlph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlph_pkg::PRIME_W-1:0]      cfg_data
);
    import mlph_pkg::*;

    logic                   q_valid;
    logic                   q_pop;
    item_t                  q_item;
    logic                   emit_can_load;
    logic                   snap_load;
    logic [LANES-1:0][31:0] snap_hash;

    mlph_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    mlph_lanes u_lanes (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_item        (q_item),
        .emit_can_load (emit_can_load),
        .snap_load     (snap_load),
        .snap_hash     (snap_hash)
    );

    mlph_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .snap_load     (snap_load),
        .snap_hash     (snap_hash),
        .emit_can_load (emit_can_load),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

    `MLPH_ASSERT_IMP(a_load_only_when_free, clk, rst_n, snap_load, emit_can_load)
    `MLPH_ASSERT_NEXT(a_load_shows_result, clk, rst_n, snap_load, m_tvalid && (m_tuser == '0))
    `MLPH_ASSERT_IMP(a_tlast_on_final_lane, clk, rst_n, m_tvalid, m_tlast == (m_tuser == LANE_W'(LANES - 1)))
    `MLPH_ASSERT_IMP(a_no_pop_when_empty, clk, rst_n, q_pop, q_valid)

endmodule

// File: dv/tb_multi_lane_poly_string_hash.sv
`timescale 1ns / 100ps

module tb_multi_lane_poly_string_hash;
    import mlph_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIME_3 = 2'd3;
    localparam logic [CFG_IDX_W-1:0] PRIME_REG_IDX [4] =
        '{REG_PRIME_0, REG_PRIME_1, REG_PRIME_2, REG_PRIME_3};

    localparam longint MODULUS     = longint'(HASH_MOD);
    localparam int     DRAIN_TICKS = 16;
    localparam int     RANDOM_ITEMS = 340;

    typedef struct {
        logic [7:0] key_byte;
        logic       has_byte;
        logic       end_of_key;
        int         gap;
    } key_item_t;

    typedef struct {
        logic [LANE_W-1:0] lane;
        logic [31:0]       hash_value;
        logic              last_lane;
    } lane_hash_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'd0;   // key_byte
    logic                 s_tuser = 1'b0;   // has_byte
    logic                 s_tlast = 1'b0;   // end_of_key
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;          // hash_value
    logic [LANE_W-1:0]    m_tuser;          // lane
    logic                 m_tlast;          // last_lane
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PRIME_W-1:0]   cfg_data = '0;

    // predictor state
    logic [PRIME_W-1:0] prime_q [4];
    logic [31:0]        hash_q [4];
    logic [31:0]        power_q [4];
    bit                 fresh_q;

    key_item_t  key_item_q [$];
    lane_hash_t hash_expect_q [$];

    int items_shown = 0;
    int items_taken = 0;
    int tx_wait = 0;
    int results_seen = 0;
    int results_acked = 0;
    int rx_stall = 0;
    int fail_cnt = 0;
    int keyed_items = 0;
    bit quiet_tx = 1'b0;
    bit quiet_rx = 1'b0;

    multi_lane_poly_string_hash dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void hash_reload();
        for (int l = 0; l < 4; l++)
        begin
            hash_q[l]  = HASH_SEED;
            power_q[l] = {1'b0, prime_q[l]};
        end
        fresh_q = 1'b1;
    endfunction

    function automatic void hash_reset();
        for (int l = 0; l < 4; l++)
            prime_q[l] = PRIME_RESET[l];
        hash_reload();
    endfunction

    function automatic void hash_prime_write(input int lane_no, input logic [PRIME_W-1:0] value);
        prime_q[lane_no] = value;
        // between keys the power word follows the new prime at once
        if (fresh_q)
            power_q[lane_no] = {1'b0, value};
    endfunction

    function automatic void hash_take(input logic [7:0] kb, input logic hb, input logic eok);
        longint     ch;
        longint     prod;
        longint     rem;
        lane_hash_t res;
        ch = longint'($signed(kb));
        // a zero character never belongs to a key
        if (hb && ch != 0)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                prod = longint'($signed(power_q[l])) * ch;
                rem = prod % MODULUS;
                hash_q[l] = hash_q[l] + rem[31:0];
                power_q[l] = power_q[l] * {1'b0, prime_q[l]};
            end
            fresh_q = 1'b0;
        end
        if (eok)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                res.lane       = l[LANE_W-1:0];
                res.hash_value = hash_q[l];
                res.last_lane  = (l == LANES - 1);
                hash_expect_q.push_back(res);
            end
            hash_reload();
        end
    endfunction

    // sender
    always @(negedge clk)
    begin : key_driver
        logic      nv;
        key_item_t nxt;
        if (rst_n)
        begin
            nv = s_tvalid;
            if (items_taken == items_shown)
            begin
                nv = 1'b0;
                if (key_item_q.size() > 0)
                begin
                    if (tx_wait < key_item_q[0].gap)
                        tx_wait++;
                    else
                    begin
                        nxt = key_item_q.pop_front();
                        s_tdata <= nxt.key_byte;
                        s_tuser <= nxt.has_byte;
                        s_tlast <= nxt.end_of_key;
                        nv = 1'b1;
                        items_shown++;
                        tx_wait = 0;
                    end
                end
            end
            s_tvalid <= nv;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            hash_take(s_tdata, s_tuser, s_tlast);
            items_taken++;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (results_acked != results_seen)
        begin
            results_acked = results_seen;
            rx_stall = quiet_rx ? 0 : $urandom_range(0, 6);
        end
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : hash_monitor
        lane_hash_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (hash_expect_q.size() == 0)
            begin
                $error("unexpected result transfer: lane %0d, hash_value %0d",
                       m_tuser, $signed(m_tdata));
                fail_cnt++;
            end
            else
            begin
                exp_res = hash_expect_q.pop_front();
                if (m_tuser !== exp_res.lane)
                begin
                    $error("lane: expected %0d, got %0d", exp_res.lane, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata !== exp_res.hash_value)
                begin
                    $error("hash_value: expected %0d, got %0d",
                           $signed(exp_res.hash_value), $signed(m_tdata));
                    fail_cnt++;
                end
                if (m_tlast !== exp_res.last_lane)
                begin
                    $error("last_lane: expected %0d, got %0d", exp_res.last_lane, m_tlast);
                    fail_cnt++;
                end
            end
            results_seen++;
        end
    end

    task automatic push_item(input logic [7:0] kb, input logic hb, input logic eok);
        key_item_t it;
        it.key_byte   = kb;
        it.has_byte   = hb;
        it.end_of_key = eok;
        it.gap        = quiet_tx ? 0 : $urandom_range(0, 6);
        key_item_q.push_back(it);
        if ((hb && kb != 8'd0) || eok)
            keyed_items++;
    endtask

    task automatic push_random_key(input int max_len, input bit finish_key);
        int len;
        int r;
        len = $urandom_range(0, max_len);
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else if (r < 8)
                push_item(8'd0, 1'b1, 1'b0);
            else
                push_item(8'($urandom_range(1, 255)), 1'b1, 1'b0);
        end
        if (finish_key)
        begin
            if ($urandom_range(0, 1))
                push_item(8'($urandom_range(1, 255)), 1'b1, 1'b1);
            else
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // hold off until everything has drained through the block
    task automatic wait_idle();
        while (key_item_q.size() > 0 || items_taken != items_shown
               || hash_expect_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_TICKS) @(negedge clk);
    endtask

    task automatic set_prime(input int lane_no, input logic [PRIME_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= PRIME_REG_IDX[lane_no];
        cfg_data  <= value;
        hash_prime_write(lane_no, value);
    endtask

    task automatic cfg_release();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PRIME_W-1:0] draw_prime();
        logic [31:0] raw;
        case ($urandom_range(0, 9))
            0: raw = 32'd0;
            1: raw = 32'd1;
            2: raw = 32'd2;
            3: raw = 32'h7fff_ffff;
            default: raw = $urandom() & 32'h7fff_ffff;
        endcase
        return raw[PRIME_W-1:0];
    endfunction

    initial
    begin
        int phase_start;
        hash_reset();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset primes
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h7f, 1'b1, 1'b1);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'h55, 1'b0, 1'b0);
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        push_item(8'h5a, 1'b0, 1'b1);
        wait_idle();

        // extreme primes between keys
        set_prime(0, 31'd0);
        set_prime(1, 31'd1);
        set_prime(2, 31'h7fff_ffff);
        set_prime(3, 31'd2);
        cfg_release();
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);

        // prime change in the middle of a key
        push_item(8'h41, 1'b1, 1'b0);
        push_item(8'h42, 1'b1, 1'b0);
        wait_idle();
        set_prime(0, 31'd13);
        set_prime(2, 31'd3);
        cfg_release();
        push_item(8'h43, 1'b1, 1'b0);
        push_item(8'h44, 1'b1, 1'b1);
        wait_idle();

        keyed_items = 0;
        for (int p = 0; keyed_items < RANDOM_ITEMS; p++)
        begin
            quiet_tx = (p % 4 == 1);
            quiet_rx = (p % 4 == 1) || (p % 4 == 3);
            phase_start = keyed_items;
            while (keyed_items - phase_start < 70)
                push_random_key(($urandom_range(0, 9) == 0) ? 40 : 10, 1'b1);
            if ($urandom_range(0, 1))
            begin
                push_random_key(6, 1'b0);
                push_item(8'($urandom_range(1, 255)), 1'b1, 1'b0);
                wait_idle();
                set_prime($urandom_range(0, 3), draw_prime());
                cfg_release();
                push_random_key(4, 1'b1);
            end
            wait_idle();
            for (int l = 0; l < 4; l++)
                if ($urandom_range(0, 1))
                    set_prime(l, draw_prime());
            cfg_release();
        end

        wait_idle();
        if (fail_cnt == 0 && hash_expect_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
